FILE: rtl/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and coefficient table for the bounce easing curve unit.
// ----------------------------------------------------------------------------
package bec_pkg;

   localparam int OUT_W = 17;
   localparam int FUNC_W = 2;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      MODE_IN    = 2'd0,
      MODE_OUT   = 2'd1,
      MODE_INOUT = 2'd2,
      MODE_OUTIN = 2'd3
   } mode_type;

   // per-item control that rides along with the datapath
   typedef struct packed {
      logic       valid;
      mode_type   mode;
      logic       upper;   // in-out: second half of the curve
      logic [2:0] seg;     // curve segment
   } ctl_type;

   // a + b*t + c*t^2 in 1/16 units, plus offset k in 1/1024 units
   typedef struct packed {
      logic signed [9:0] a;
      logic signed [9:0] b;
      logic signed [9:0] c;
      logic [10:0]       k;
   } coef_type;

   function automatic coef_type seg_coef(input logic outin, input logic [2:0] seg);
      coef_type cf;
      cf = '{a: 10'sd0, b: 10'sd0, c: 10'sd121, k: 11'd0};
      case ({outin, seg})
         4'b0_000: cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd121,  k: 11'd0};
         4'b0_001: cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd121,  k: 11'd768};
         4'b0_010: cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd121,  k: 11'd960};
         4'b0_011: cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd121,  k: 11'd1008};
         4'b1_000: cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd242,  k: 11'd0};
         4'b1_001: cf = '{a: 10'sd24,   b: -10'sd132, c: 10'sd242,  k: 11'd0};
         4'b1_010: cf = '{a: 10'sd48,   b: -10'sd198, c: 10'sd242,  k: 11'd0};
         4'b1_011: cf = '{a: 10'sd63,   b: -10'sd231, c: 10'sd242,  k: 11'd0};
         4'b1_100: cf = '{a: -10'sd58,  b: 10'sd253,  c: -10'sd242, k: 11'd0};
         4'b1_101: cf = '{a: -10'sd76,  b: 10'sd286,  c: -10'sd242, k: 11'd0};
         4'b1_110: cf = '{a: -10'sd118, b: 10'sd352,  c: -10'sd242, k: 11'd0};
         4'b1_111: cf = '{a: -10'sd226, b: 10'sd484,  c: -10'sd242, k: 11'd0};
         default:  cf = '{a: 10'sd0,    b: 10'sd0,    c: 10'sd121,  k: 11'd0};
      endcase
      return cf;
   endfunction

endpackage

FILE: rtl/bounce_easing_curve_unit.sv
// ----------------------------------------------------------------------------
// bounce_easing_curve_unit
// Bounce easing curve in unsigned fixed point (1.0 = 2^FRAC_BITS): in, out,
// in-out and out-in, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  request  | start, busy, req_func, req_position    | taken when start && !busy
//  response | rsp_valid, rsp_eased_value             | one-cycle strobe, no hold
//
//  One item per cycle. Each item passes through five register stages in order:
//  clamp/segment, square, coefficient, sum, round/saturate.
//  The square is formed in stage two.
//  busy is high only during reset; reset clears the valid bits of every stage.
//  The receiver cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
module bounce_easing_curve_unit import bec_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [OUT_W-1:0]   req_position,
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_eased_value
);

   ctl_type                         s1_ctl;
   ctl_type                         s4_ctl;
   logic [FRAC_BITS:0]              s1_m;
   logic [FRAC_BITS:0]              s1_t;
   logic signed [2*FRAC_BITS+12:0]  s4_acc;

   assign busy = reset;

   bec_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .in_func     (req_func),
      .in_position (req_position),
      .s1_ctl      (s1_ctl),
      .s1_m        (s1_m),
      .s1_t        (s1_t)
   );

   bec_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
      .clock  (clock),
      .reset  (reset),
      .s1_ctl (s1_ctl),
      .s1_m   (s1_m),
      .s1_t   (s1_t),
      .s4_ctl (s4_ctl),
      .s4_acc (s4_acc)
   );

   bec_final #(.FRAC_BITS(FRAC_BITS)) u_final (
      .clock     (clock),
      .reset     (reset),
      .s4_ctl    (s4_ctl),
      .s4_acc    (s4_acc),
      .out_valid (rsp_valid),
      .out_value (rsp_eased_value)
   );

endmodule

FILE: rtl/bec_prep.sv
// ----------------------------------------------------------------------------
// bec_prep
// Stage 1: clamp, fold the mode into a curve argument, pick the segment
// and form the operand to be squared.
// ----------------------------------------------------------------------------
module bec_prep import bec_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [FUNC_W-1:0]    in_func,
   input  logic [OUT_W-1:0]     in_position,
   output ctl_type              s1_ctl,
   output logic [FRAC_BITS:0]   s1_m,
   output logic [FRAC_BITS:0]   s1_t
);

   localparam int W  = FRAC_BITS + 2;
   localparam int CW = (W > OUT_W) ? W : OUT_W;

   localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] B2_11  = ((64'd2  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B4_11  = ((64'd4  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B5_11  = ((64'd5  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B6_11  = ((64'd6  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B7_11  = ((64'd7  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B8_11  = ((64'd8  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B9_11  = ((64'd9  << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B10_11 = ((64'd10 << (FRAC_BITS + 1)) + 64'd11) / 64'd22;
   localparam logic [63:0] B21_22 = ((64'd21 << (FRAC_BITS + 1)) + 64'd22) / 64'd44;

   localparam logic [W-1:0] ONE_W  = W'(ONE64);
   localparam logic [W-1:0] HALF_W = W'(ONE64 >> 1);

   ctl_type              s1_ctl_ff, s1_ctl_in;
   logic [FRAC_BITS:0]   s1_m_ff, s1_m_in;
   logic [FRAC_BITS:0]   s1_t_ff, s1_t_in;

   logic [CW-1:0]        xe;
   logic [W-1:0]         xc;
   logic [W-1:0]         x2;
   logic [W-1:0]         u;
   logic [W-1:0]         center;
   logic [2:0]           bseg;
   logic [2:0]           oseg;
   logic signed [W:0]    ds;
   logic signed [W:0]    ad;
   mode_type             mode;

   always_comb begin
      mode = mode_type'(in_func);
      xe = CW'(in_position);
      if (xe > CW'(ONE64)) begin
         xe = CW'(ONE64);
      end
      xc = W'(xe);
      x2 = xc << 1;

      case (mode)
         MODE_IN:    u = ONE_W - xc;
         MODE_OUT:   u = xc;
         MODE_INOUT: begin
            if (xc < HALF_W) begin
               u = ONE_W - x2;
            end else begin
               u = x2 - ONE_W;
            end
         end
         default:    u = xc;
      endcase

      // quadratic bounce: four arcs, each centered on its own bounce
      if (u < W'(B4_11)) begin
         bseg = 3'd0;
         center = '0;
      end else if (u < W'(B8_11)) begin
         bseg = 3'd1;
         center = W'(B6_11);
      end else if (u < W'(B10_11)) begin
         bseg = 3'd2;
         center = W'(B9_11);
      end else begin
         bseg = 3'd3;
         center = W'(B21_22);
      end
      ds = $signed({1'b0, u}) - $signed({1'b0, center});
      ad = ds[W] ? -ds : ds;

      // out-in polynomial segments; upper half bounds are inclusive
      if (xc < W'(B2_11)) begin
         oseg = 3'd0;
      end else if (xc < W'(B4_11)) begin
         oseg = 3'd1;
      end else if (xc < W'(B5_11)) begin
         oseg = 3'd2;
      end else if (xc < HALF_W) begin
         oseg = 3'd3;
      end else if (xc <= W'(B6_11)) begin
         oseg = 3'd4;
      end else if (xc <= W'(B7_11)) begin
         oseg = 3'd5;
      end else if (xc <= W'(B9_11)) begin
         oseg = 3'd6;
      end else begin
         oseg = 3'd7;
      end

      s1_ctl_in.valid = in_valid;
      s1_ctl_in.mode  = mode;
      s1_ctl_in.upper = (xc >= HALF_W);
      s1_t_in = xc[FRAC_BITS:0];
      if (mode == MODE_OUTIN) begin
         s1_ctl_in.seg = oseg;
         s1_m_in = xc[FRAC_BITS:0];
      end else begin
         s1_ctl_in.seg = bseg;
         s1_m_in = ad[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
      end
      s1_ctl_ff.mode  <= s1_ctl_in.mode;
      s1_ctl_ff.upper <= s1_ctl_in.upper;
      s1_ctl_ff.seg   <= s1_ctl_in.seg;
      s1_m_ff <= s1_m_in;
      s1_t_ff <= s1_t_in;
   end

   assign s1_ctl = s1_ctl_ff;
   assign s1_m   = s1_m_ff;
   assign s1_t   = s1_t_ff;

endmodule

FILE: rtl/bec_arith.sv
// ----------------------------------------------------------------------------
// bec_arith
// Stages 2 to 4: square and linear term, quadratic coefficient, then the
// exact sum a + b*t + c*m^2 at 2F+4 fraction bits.
// ----------------------------------------------------------------------------
module bec_arith import bec_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_type                       s1_ctl,
   input  logic [FRAC_BITS:0]            s1_m,
   input  logic [FRAC_BITS:0]            s1_t,
   output ctl_type                       s4_ctl,
   output logic signed [2*FRAC_BITS+12:0] s4_acc
);

   localparam int SQW = 2 * FRAC_BITS + 2;
   localparam int BW  = FRAC_BITS + 12;
   localparam int AW  = 2 * FRAC_BITS + 13;

   ctl_type               s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [SQW-1:0]        s2_sq_ff, s2_sq_in;
   logic signed [BW-1:0]  s2_bt_ff, s2_bt_in;
   logic signed [BW-1:0]  s3_bt_ff;
   logic signed [AW-1:0]  s3_prod_ff, s3_prod_in;
   logic signed [AW-1:0]  s4_acc_ff, s4_acc_in;

   coef_type              cf2, cf3, cf4;
   logic signed [AW-1:0]  sq_s, s121, s242;

   // stage 2
   always_comb begin
      cf2 = seg_coef(s1_ctl.mode == MODE_OUTIN, s1_ctl.seg);
      s2_sq_in = s1_m * s1_m;
      s2_bt_in = BW'(cf2.b) * BW'($signed({1'b0, s1_t}));
   end

   // stage 3: c is 121, 242 or -242, so shift and add
   always_comb begin
      cf3  = seg_coef(s2_ctl_ff.mode == MODE_OUTIN, s2_ctl_ff.seg);
      sq_s = AW'($signed({1'b0, s2_sq_ff}));
      s121 = (sq_s <<< 7) - (sq_s <<< 3) + sq_s;
      s242 = s121 <<< 1;
      if (cf3.c == 10'sd121) begin
         s3_prod_in = s121;
      end else if (cf3.c == 10'sd242) begin
         s3_prod_in = s242;
      end else begin
         s3_prod_in = -s242;
      end
   end

   // stage 4
   always_comb begin
      cf4 = seg_coef(s3_ctl_ff.mode == MODE_OUTIN, s3_ctl_ff.seg);
      s4_acc_in = s3_prod_ff + (AW'(cf4.a) <<< (2 * FRAC_BITS))
                + (AW'(s3_bt_ff) <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
      end else begin
         s2_ctl_ff.valid <= s1_ctl.valid;
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
         s4_ctl_ff.valid <= s3_ctl_ff.valid;
      end
      s2_ctl_ff.mode  <= s1_ctl.mode;
      s2_ctl_ff.upper <= s1_ctl.upper;
      s2_ctl_ff.seg   <= s1_ctl.seg;
      s3_ctl_ff.mode  <= s2_ctl_ff.mode;
      s3_ctl_ff.upper <= s2_ctl_ff.upper;
      s3_ctl_ff.seg   <= s2_ctl_ff.seg;
      s4_ctl_ff.mode  <= s3_ctl_ff.mode;
      s4_ctl_ff.upper <= s3_ctl_ff.upper;
      s4_ctl_ff.seg   <= s3_ctl_ff.seg;
      s2_sq_ff   <= s2_sq_in;
      s2_bt_ff   <= s2_bt_in;
      s3_bt_ff   <= s2_bt_ff;
      s3_prod_ff <= s3_prod_in;
      s4_acc_ff  <= s4_acc_in;
   end

   assign s4_ctl = s4_ctl_ff;
   assign s4_acc = s4_acc_ff;

endmodule

FILE: rtl/bec_final.sv
// ----------------------------------------------------------------------------
// bec_final
// Stage 5: round, add the bounce offset, saturate, unfold the mode and
// register the result.
// ----------------------------------------------------------------------------
module bec_final import bec_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctl_type                        s4_ctl,
   input  logic signed [2*FRAC_BITS+12:0] s4_acc,
   output logic                           out_valid,
   output logic [OUT_W-1:0]               out_value
);

   localparam int W  = FRAC_BITS + 2;
   localparam int AW = 2 * FRAC_BITS + 13;
   localparam int RW = AW - (FRAC_BITS + 4);
   localparam int KW = FRAC_BITS + 13;
   localparam int CW = (W > OUT_W) ? W : OUT_W;
   localparam logic [W-1:0] ONE_W = W'(64'd1 << FRAC_BITS);

   logic                  out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]      out_value_ff, out_value_in;

   coef_type              cf;
   logic [KW-1:0]         kx;
   logic signed [AW-1:0]  sum;
   logic [RW-1:0]         rq;
   logic [RW-1:0]         r;
   logic [W-1:0]          rw;
   logic [W-1:0]          y;
   logic [CW-1:0]         ye;

   always_comb begin
      cf  = seg_coef(s4_ctl.mode == MODE_OUTIN, s4_ctl.seg);
      // offset in 1/1024 units, rounded half up to the fraction width
      kx  = (KW'(cf.k) << (FRAC_BITS + 1)) + KW'(1024);
      sum = s4_acc + (AW'(1) <<< (FRAC_BITS + 3));
      rq  = RW'(sum >>> (FRAC_BITS + 4));
      if (!s4_acc[AW-1] && (s4_acc != '0)) begin
         r = rq;
      end else begin
         r = '0;
      end
      r = r + RW'(kx >> 11);
      if (r > RW'(ONE_W)) begin
         r = RW'(ONE_W);
      end
      rw = W'(r);

      case (s4_ctl.mode)
         MODE_IN:    y = ONE_W - rw;
         MODE_OUT:   y = rw;
         MODE_INOUT: begin
            if (s4_ctl.upper) begin
               y = (rw + ONE_W + W'(1)) >> 1;
            end else begin
               y = (ONE_W - rw + W'(1)) >> 1;
            end
         end
         default:    y = rw;
      endcase
      if (y > ONE_W) begin
         y = ONE_W;
      end
      ye = CW'(y);
      if (ye > CW'(OUT_MAX)) begin
         ye = CW'(OUT_MAX);
      end
      out_value_in = OUT_W'(ye);
      out_valid_in = s4_ctl.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule

FILE: rtl/bec_checker.sv
// ----------------------------------------------------------------------------
// bec_checker
// Port-level checks for the bounce easing curve unit, bound to the top level.
// ----------------------------------------------------------------------------
module bec_checker import bec_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [FUNC_W-1:0]  req_func,
   input logic [OUT_W-1:0]   req_position,
   input logic               rsp_valid,
   input logic [OUT_W-1:0]   rsp_eased_value
);

   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
   localparam logic [OUT_W-1:0] TOP =
      (ONE64 > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(ONE64);

   // every accepted item comes out as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("item accepted without a result five cycles later");

   // no result appears that was not requested
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without a matching item");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eased_value <= TOP))
      else $error("eased value above 1.0");

   // bounce out starts at zero
   a_endpoints: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == MODE_OUT) && (req_position == '0))
      |-> ##5 (rsp_eased_value == '0))
      else $error("bounce out at zero is not zero");

endmodule

bind bounce_easing_curve_unit bec_checker #(.FRAC_BITS(FRAC_BITS)) u_bec_checker (.*);
